@@ rtl/amvmm_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// amvmm_pkg
// Shared types and fixed widths for the set statistics block.
// ----------------------------------------------------------------------------
package amvmm_pkg;

    localparam int SAMPLE_W    = 16;
    localparam int COUNT_W     = 11;
    localparam int MEAN_W      = 16;
    localparam int VAR_W       = 39;
    localparam int VAR_FRAC    = 8;
    localparam int IN_TDATA_W  = 16;
    localparam int OUT_FIELD_W = COUNT_W + MEAN_W + VAR_W + 2 * SAMPLE_W;
    localparam int OUT_TDATA_W = ((OUT_FIELD_W + 7) / 8) * 8;

    typedef enum logic [2:0] {
        ST_ACC,
        ST_MUL,
        ST_SQ,
        ST_SUB,
        ST_MEAN,
        ST_VAR,
        ST_OUT
    } t_state;

    // controller to datapath
    typedef struct packed {
        logic acc_en;
        logic mul_en;
        logic sq_en;
        logic sub_en;
        logic start_mean;
        logic start_var;
        logic cap_mean;
        logic load_out;
    } t_cmd;

    // datapath to controller
    typedef struct packed {
        logic div_done;
        logic out_free;
    } t_stat;

endpackage
`default_nettype wire

@@ rtl/amvmm_div.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// amvmm_div
// Restoring divider, one quotient bit per cycle. The dividend is taken
// MSB first, so a short dividend is loaded at the top with fewer steps.
// ----------------------------------------------------------------------------
module amvmm_div #(
    parameter int DVD_W  = 61,
    parameter int DVS_W  = 22,
    parameter int STEP_W = 6
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_start,
    input  wire logic [DVD_W-1:0]  i_dividend,
    input  wire logic [DVS_W-1:0]  i_divisor,
    input  wire logic [STEP_W-1:0] i_steps,
    output logic      [DVD_W-1:0]  o_quotient,
    output logic                   o_done
);

    logic [DVD_W-1:0]  r_quo;
    logic [DVS_W-1:0]  r_rem;
    logic [DVS_W-1:0]  r_dvs;
    logic [STEP_W-1:0] r_steps;
    logic              r_busy;
    logic              r_done;

    logic [DVS_W:0]    w_shift;
    logic              w_ge;
    logic [DVS_W:0]    w_diff;

    assign w_shift = {r_rem, r_quo[DVD_W-1]};
    assign w_ge    = (w_shift >= {1'b0, r_dvs});
    assign w_diff  = w_shift - {1'b0, r_dvs};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy  <= 1'b0;
            r_done  <= 1'b0;
            r_steps <= '0;
        end else if (i_start) begin
            r_busy  <= 1'b1;
            r_done  <= 1'b0;
            r_steps <= i_steps;
        end else if (r_busy) begin
            r_steps <= r_steps - 1'b1;
            if (r_steps == STEP_W'(1)) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end else begin
            r_done <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_quo <= i_dividend;
            r_rem <= '0;
            r_dvs <= i_divisor;
        end else if (r_busy) begin
            r_quo <= {r_quo[DVD_W-2:0], w_ge};
            r_rem <= w_ge ? w_diff[DVS_W-1:0] : w_shift[DVS_W-1:0];
        end
    end

    assign o_quotient = r_quo;
    assign o_done     = r_done;

endmodule
`default_nettype wire

@@ rtl/amvmm_dp.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// amvmm_dp
// Accumulators, product and difference registers, the shared divider and
// the output register of the set statistics block.
// ----------------------------------------------------------------------------
module amvmm_dp #(
    parameter int MAX_COUNT = 1024
) (
    input  wire logic                                  i_clk,
    input  wire logic                                  i_rst_n,
    input  wire amvmm_pkg::t_cmd                       i_cmd,
    output amvmm_pkg::t_stat                           o_stat,
    input  wire logic [amvmm_pkg::SAMPLE_W-1:0]        i_sample,
    output logic                                       o_valid,
    input  wire logic                                  i_ready,
    output logic      [amvmm_pkg::OUT_TDATA_W-1:0]     o_data,
    output logic                                       o_overflow
);
    import amvmm_pkg::*;

    localparam int CNT_W  = $clog2(MAX_COUNT + 1);
    localparam int SUM_W  = SAMPLE_W + CNT_W;
    localparam int SQ_W   = 2 * SAMPLE_W - 1 + CNT_W;
    localparam int MAG_W  = SAMPLE_W - 1 + CNT_W;
    localparam int MSQ_W  = 2 * MAG_W;
    localparam int NUM_W  = CNT_W + SQ_W;
    localparam int DEN_W  = 2 * CNT_W;
    localparam int DVD_W  = NUM_W + VAR_FRAC;
    localparam int STEP_W = $clog2(DVD_W + 1);
    localparam int PAD_W  = OUT_TDATA_W - OUT_FIELD_W;

    logic        [CNT_W-1:0]    r_cnt;
    logic signed [SUM_W-1:0]    r_sum;
    logic        [SQ_W-1:0]     r_sumsq;
    logic signed [SAMPLE_W-1:0] r_max;
    logic signed [SAMPLE_W-1:0] r_min;
    logic                       r_drop;

    logic        [MAG_W-1:0]    r_mag;
    logic                       r_neg;
    logic        [NUM_W-1:0]    r_num;
    logic        [DEN_W-1:0]    r_den;
    logic        [MSQ_W-1:0]    r_msq;
    logic        [NUM_W-1:0]    r_diff;
    logic signed [MEAN_W-1:0]   r_mean;

    logic                       r_out_valid;
    logic [OUT_FIELD_W-1:0]     r_out_data;
    logic                       r_out_ovf;

    logic signed [SAMPLE_W-1:0]   w_s;
    logic signed [2*SAMPLE_W-1:0] w_prod;
    logic                         w_full;
    logic [MAG_W-1:0]             w_mag;
    logic                         w_div_start;
    logic [DVD_W-1:0]             w_dividend;
    logic [DEN_W-1:0]             w_divisor;
    logic [STEP_W-1:0]            w_steps;
    logic [DVD_W-1:0]             w_quo;
    logic                         w_done;
    logic [MAG_W-1:0]             w_qm;

    assign w_s    = i_sample;
    assign w_prod = w_s * w_s;
    assign w_full = (r_cnt == CNT_W'(MAX_COUNT));
    assign w_mag  = r_sum[SUM_W-1] ? MAG_W'(-r_sum) : MAG_W'(r_sum);

    // accumulation, one sample a cycle while acc_en is set
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_cmd.load_out) begin
            r_cnt   <= '0;
            r_sum   <= '0;
            r_sumsq <= '0;
            r_max   <= '0;
            r_min   <= '0;
            r_drop  <= 1'b0;
        end else if (i_cmd.acc_en) begin
            if (w_full) begin
                r_drop <= 1'b1;
            end else begin
                r_cnt   <= r_cnt + 1'b1;
                r_sum   <= r_sum + SUM_W'(w_s);
                r_sumsq <= r_sumsq + SQ_W'($unsigned(w_prod));
                if (r_cnt == '0 || w_s > r_max) begin
                    r_max <= w_s;
                end
                if (r_cnt == '0 || w_s < r_min) begin
                    r_min <= w_s;
                end
            end
        end
    end

    // products and difference for n*sumsq - sum^2 and n^2
    always_ff @(posedge i_clk) begin
        if (i_cmd.mul_en) begin
            r_mag <= w_mag;
            r_neg <= r_sum[SUM_W-1];
            r_num <= NUM_W'(r_cnt) * NUM_W'(r_sumsq);
            r_den <= DEN_W'(r_cnt) * DEN_W'(r_cnt);
        end
        if (i_cmd.sq_en) begin
            r_msq <= MSQ_W'(r_mag) * MSQ_W'(r_mag);
        end
        if (i_cmd.sub_en) begin
            r_diff <= r_num - NUM_W'(r_msq);
        end
        if (i_cmd.cap_mean) begin
            r_mean <= MEAN_W'(r_neg ? (MAG_W'(0) - w_qm) : w_qm);
        end
    end

    // divider operands: mean first, then the scaled variance
    assign w_div_start = i_cmd.start_mean | i_cmd.start_var;
    assign w_dividend  = i_cmd.start_var ? {r_diff, {VAR_FRAC{1'b0}}}
                                         : {r_mag, {(DVD_W - MAG_W){1'b0}}};
    assign w_divisor   = i_cmd.start_var ? r_den : DEN_W'(r_cnt);
    assign w_steps     = i_cmd.start_var ? STEP_W'(DVD_W) : STEP_W'(MAG_W);
    assign w_qm        = w_quo[MAG_W-1:0];

    amvmm_div #(
        .DVD_W  (DVD_W),
        .DVS_W  (DEN_W),
        .STEP_W (STEP_W)
    ) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_div_start),
        .i_dividend (w_dividend),
        .i_divisor  (w_divisor),
        .i_steps    (w_steps),
        .o_quotient (w_quo),
        .o_done     (w_done)
    );

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.load_out) begin
            r_out_valid <= 1'b1;
        end else if (i_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_out) begin
            r_out_data <= {r_min, r_max, VAR_W'(w_quo), r_mean, COUNT_W'(r_cnt)};
            r_out_ovf  <= r_drop;
        end
    end

    assign o_stat.div_done = w_done;
    assign o_stat.out_free = !r_out_valid || i_ready;
    assign o_valid         = r_out_valid;
    assign o_data          = {{PAD_W{1'b0}}, r_out_data};
    assign o_overflow      = r_out_ovf;

endmodule
`default_nettype wire

@@ rtl/amvmm_ctrl.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// amvmm_ctrl
// Sequencer: accumulate, then multiply, subtract, two divisions and the
// hand-over to the output register.
// ----------------------------------------------------------------------------
module amvmm_ctrl (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_valid,
    input  wire logic             i_last,
    output logic                  o_ready,
    output amvmm_pkg::t_cmd       o_cmd,
    input  wire amvmm_pkg::t_stat i_stat
);
    import amvmm_pkg::*;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_ACC;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_ACC: begin
                if (i_valid && i_last) begin
                    n_state = ST_MUL;
                end
            end
            ST_MUL:  n_state = ST_SQ;
            ST_SQ:   n_state = ST_SUB;
            ST_SUB:  n_state = ST_MEAN;
            ST_MEAN: begin
                if (i_stat.div_done) begin
                    n_state = ST_VAR;
                end
            end
            ST_VAR: begin
                if (i_stat.div_done) begin
                    n_state = ST_OUT;
                end
            end
            ST_OUT: begin
                if (i_stat.out_free) begin
                    n_state = ST_ACC;
                end
            end
            default: n_state = ST_ACC;
        endcase
    end

    always_comb begin
        o_cmd   = '0;
        o_ready = 1'b0;
        case (r_state)
            ST_ACC: begin
                o_ready      = 1'b1;
                o_cmd.acc_en = i_valid;
            end
            ST_MUL: o_cmd.mul_en = 1'b1;
            ST_SQ: begin
                o_cmd.sq_en      = 1'b1;
                o_cmd.start_mean = 1'b1;
            end
            ST_SUB: o_cmd.sub_en = 1'b1;
            ST_MEAN: begin
                o_cmd.cap_mean  = i_stat.div_done;
                o_cmd.start_var = i_stat.div_done;
            end
            ST_VAR: begin
            end
            ST_OUT: o_cmd.load_out = i_stat.out_free;
            default: begin
            end
        endcase
    end

endmodule
`default_nettype wire

@@ rtl/array_mean_variance_min_max.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// array_mean_variance_min_max
// Count, mean, population variance, maximum and minimum of a set of samples.
// ----------------------------------------------------------------------------
// Input stream: one signed sample per item in tdata, tlast on the final
// sample of a set. Samples are accumulated at one item per cycle. After the
// tlast item the input stalls while the results are formed: products, one
// subtraction, then a shared bit-serial divider runs the mean (26 steps)
// and the variance (61 steps) at the default MAX_COUNT, after which the
// result is loaded into the output register.
// Output stream: one item per set, held in an output register until taken.
// The block returns to accumulating as soon as the result is loaded, so a
// new set streams in while the receiver stalls; only the next result waits
// if the previous one has not been taken.
// Samples beyond MAX_COUNT are dropped and flagged in tuser.
// Reset clears the accumulators and the output valid; no clearing pass.
// ----------------------------------------------------------------------------
module array_mean_variance_min_max #(
    parameter int MAX_COUNT = 1024
) (
    input  wire logic                                   i_clk,
    input  wire logic                                   i_rst_n,
    input  wire logic                                   i_s_tvalid,
    output logic                                        o_s_tready,
    input  wire logic [amvmm_pkg::IN_TDATA_W-1:0]       i_s_tdata,  // sample
    input  wire logic                                   i_s_tlast,  // is_last
    output logic                                        o_m_tvalid,
    input  wire logic                                   i_m_tready,
    // count, mean, variance_q8, maximum, minimum, zero pad
    output logic      [amvmm_pkg::OUT_TDATA_W-1:0]      o_m_tdata,
    output logic                                        o_m_tuser   // overflow
);
    import amvmm_pkg::*;

    t_cmd  w_cmd;
    t_stat w_stat;

    amvmm_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_s_tvalid),
        .i_last  (i_s_tlast),
        .o_ready (o_s_tready),
        .o_cmd   (w_cmd),
        .i_stat  (w_stat)
    );

    amvmm_dp #(
        .MAX_COUNT (MAX_COUNT)
    ) u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd      (w_cmd),
        .o_stat     (w_stat),
        .i_sample   (i_s_tdata[SAMPLE_W-1:0]),
        .o_valid    (o_m_tvalid),
        .i_ready    (i_m_tready),
        .o_data     (o_m_tdata),
        .o_overflow (o_m_tuser)
    );

endmodule
`default_nettype wire

@@ rtl/amvmm_checker.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// amvmm_checker
// Port-level checks for the set statistics block, bound to the top level.
// ----------------------------------------------------------------------------
module amvmm_checker (
    input wire logic         i_clk,
    input wire logic         i_rst_n,
    input wire logic         i_s_tvalid,
    input wire logic         o_s_tready,
    input wire logic         i_s_tlast,
    input wire logic         o_m_tvalid,
    input wire logic         i_m_tready,
    input wire logic [103:0] o_m_tdata,
    input wire logic         o_m_tuser
);

    // a stalled result stays offered
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !i_m_tready |=> o_m_tvalid)
        else $error("output item withdrawn while stalled");

    // and keeps its payload
    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !i_m_tready |=> $stable(o_m_tdata) && $stable(o_m_tuser))
        else $error("output item changed while stalled");

    // closing a set stops the input while results are formed
    a_last_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_s_tvalid && o_s_tready && i_s_tlast |=> !o_s_tready)
        else $error("input taken right after the last item of a set");

    // minimum never above maximum
    a_min_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid |-> $signed(o_m_tdata[97:82]) <= $signed(o_m_tdata[81:66]))
        else $error("minimum above maximum");

    // no result straight out of reset
    a_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_tvalid)
        else $error("output valid after reset");

endmodule

bind array_mean_variance_min_max amvmm_checker u_amvmm_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .i_s_tvalid (i_s_tvalid),
    .o_s_tready (o_s_tready),
    .i_s_tlast  (i_s_tlast),
    .o_m_tvalid (o_m_tvalid),
    .i_m_tready (i_m_tready),
    .o_m_tdata  (o_m_tdata),
    .o_m_tuser  (o_m_tuser)
);
`default_nettype wire
